@@ rtl/itfr_pkg.sv @@
// Shared types and constants of the idle timeout frame receiver.
package itfr_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_POP     = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       frame_ready;
    logic [7:0] frame_length;
    logic [7:0] pop_data;
    logic       pop_valid;
    logic       byte_dropped;
  } result_t;

  localparam logic [15:0] IDLE_TICKS_RESET = 16'd10;

endpackage

@@ rtl/itfr_stream_if.sv @@
// Valid/ready stream channel that carries one payload per transfer.
interface itfr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/idle_timeout_frame_receiver.sv @@
// Idle timeout frame receiver: ring buffer of serial bytes with frames delimited by line silence.
//
// Each transfer on the item channel carries one event: a received byte, a timer tick, a pop of
// one byte or a release of the frame flag. Every item yields exactly one transfer on the result
// channel with the ready flag, the held length (modulo the buffer depth, cut to 8 bits), the
// popped byte and a dropped indication. Byte, tick and release items form their result at the
// accepting edge, and the block takes a new item in the following cycle, provided the result
// register is free or is being drained in that same cycle. A pop item waits for the registered
// read of the ring store memory and blocks new items until its result is formed. The ring
// store holds undefined data after reset; since only written entries are ever read, no clearing
// pass is needed and the block is ready right after reset. The idle_ticks register is loaded
// through idle_ticks_we and idle_ticks_data and must only be written while no item is in flight.
module idle_timeout_frame_receiver #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 idle_ticks_we,
  input  logic [15:0]          idle_ticks_data,
  itfr_stream_if.sink          item,
  itfr_stream_if.source        result
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t              state;
  logic                out_valid;
  itfr_pkg::result_t   out_payload;

  // Ring store, written by received bytes and read by pops.
  logic [7:0]          ring_store [BUFFER_DEPTH];
  logic [7:0]          rd_data;

  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    held_cnt;
  logic [15:0]         idle_timer;
  logic                ready_flag;
  logic [7:0]          held_length;
  logic [15:0]         idle_ticks;
  logic                pop_hit;

  logic [IDX_W-1:0]    wr_idx_next;
  logic [IDX_W-1:0]    rd_idx_next;
  logic [CNT_W-1:0]    held_cnt_next;
  logic [15:0]         idle_timer_next;
  logic                ready_flag_next;
  logic [7:0]          held_length_next;
  logic                store_we;
  logic                store_re;
  logic                dropped;

  logic                accept;
  itfr_pkg::item_t     in_item;

  // The held count modulo the depth is zero both when the store is empty and when it is full.
  function automatic logic [7:0] length_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] wrapped;
    logic [31:0]      wide;
    wrapped = (cnt == FULL_CNT) ? '0 : cnt;
    wide    = 32'(wrapped);
    return wide[7:0];
  endfunction

  assign in_item      = item.payload;
  // A new item is taken only out of reset, in the idle state and when the result register will
  // be free.
  assign item.ready   = !rst && (state == S_IDLE) && (!out_valid || result.ready);
  assign accept       = item.valid && item.ready;
  assign result.valid   = out_valid;
  assign result.payload = out_payload;

  // Next-state logic of the buffer bookkeeping for the accepted item.
  always_comb begin
    wr_idx_next      = wr_idx;
    rd_idx_next      = rd_idx;
    held_cnt_next    = held_cnt;
    idle_timer_next  = idle_timer;
    ready_flag_next  = ready_flag;
    held_length_next = held_length;
    store_we         = 1'b0;
    store_re         = 1'b0;
    dropped          = 1'b0;
    if (accept) begin
      unique case (in_item.kind)
        itfr_pkg::KIND_BYTE: begin
          if (ready_flag) begin
            dropped = 1'b1;
          end else if (held_cnt == '0 || held_cnt == FULL_CNT || idle_timer != '0) begin
            // A taken byte restarts the silence timer, whether or not it finds room.
            idle_timer_next = idle_ticks;
            if (held_cnt != FULL_CNT) begin
              store_we      = 1'b1;
              wr_idx_next   = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
              held_cnt_next = held_cnt + 1'b1;
            end else begin
              dropped = 1'b1;
            end
            held_length_next = length_of(held_cnt_next);
          end else begin
            // The timer ran out with data held but no tick has closed the frame yet.
            dropped = 1'b1;
          end
        end
        itfr_pkg::KIND_TICK: begin
          if (idle_timer != '0) begin
            idle_timer_next = idle_timer - 1'b1;
          end else if (held_length != '0 && !ready_flag) begin
            ready_flag_next = 1'b1;
          end
        end
        itfr_pkg::KIND_POP: begin
          if (held_cnt != '0) begin
            store_re         = 1'b1;
            rd_idx_next      = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
            held_cnt_next    = held_cnt - 1'b1;
            held_length_next = length_of(held_cnt_next);
          end
        end
        itfr_pkg::KIND_RELEASE: begin
          ready_flag_next = 1'b0;
        end
      endcase
    end
  end

  // Synchronous memory with a registered read port.
  always_ff @(posedge clk) begin
    if (store_we) begin
      ring_store[wr_idx] <= in_item.rx_byte;
    end
    if (store_re) begin
      rd_data <= ring_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx      <= '0;
      rd_idx      <= '0;
      held_cnt    <= '0;
      idle_timer  <= '0;
      ready_flag  <= 1'b0;
      held_length <= '0;
      pop_hit     <= 1'b0;
    end else begin
      wr_idx      <= wr_idx_next;
      rd_idx      <= rd_idx_next;
      held_cnt    <= held_cnt_next;
      idle_timer  <= idle_timer_next;
      ready_flag  <= ready_flag_next;
      held_length <= held_length_next;
      if (accept) begin
        pop_hit <= store_re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= itfr_pkg::IDLE_TICKS_RESET;
    end else if (idle_ticks_we) begin
      idle_ticks <= idle_ticks_data;
    end
  end

  // Sequencer and result register. A pop waits in S_POP for the registered memory read before
  // its result is formed; all other kinds produce their result at the accepting edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_item.kind == itfr_pkg::KIND_POP) begin
              state <= S_POP;
            end else begin
              out_valid                 <= 1'b1;
              out_payload.frame_ready   <= ready_flag_next;
              out_payload.frame_length  <= held_length_next;
              out_payload.pop_data      <= '0;
              out_payload.pop_valid     <= 1'b0;
              out_payload.byte_dropped  <= dropped;
            end
          end
        end
        S_POP: begin
          state                     <= S_IDLE;
          out_valid                 <= 1'b1;
          out_payload.frame_ready   <= ready_flag;
          out_payload.frame_length  <= held_length;
          out_payload.pop_data      <= pop_hit ? rd_data : 8'd0;
          out_payload.pop_valid     <= pop_hit;
          out_payload.byte_dropped  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The held count never exceeds the store depth.
  assert property (@(posedge clk) disable iff (rst) held_cnt <= FULL_CNT)
    else $error("held count exceeds buffer depth");

  // The reported length always tracks the held count.
  assert property (@(posedge clk) disable iff (rst) held_length == length_of(held_cnt))
    else $error("held length out of step with held count");

  // The frame flag is only raised by a tick transfer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(ready_flag) |-> $past(accept && in_item.kind == itfr_pkg::KIND_TICK))
    else $error("frame flag raised without a tick");

  // While a pop waits for its memory read the result register is empty.
  assert property (@(posedge clk) disable iff (rst) state == S_POP |-> !out_valid)
    else $error("result register busy during pop read");

endmodule

@@ bench/idle_timeout_frame_receiver_tb.sv @@
// Self-checking testbench of the idle timeout frame receiver, with predictor and scoreboard.
`timescale 1ns / 100ps

module idle_timeout_frame_receiver_tb;

  // The bench is written for the default depth. The counters of the predictor are one bit wider
  // than the store index; they wrap at twice the depth, so their difference tells full from empty.
  localparam int DEPTH = 256;
  localparam int CW = $clog2(DEPTH) + 1;

  // Cycles to let pass once every expected result has arrived, before a register write or the
  // final verdict.
  localparam int SETTLE_CYCLES = 8;

  // Number of random items per configuration phase.
  localparam int PHASE_ITEMS = 200;

  // Predicts the status of every accepted item and compares it with what the block returns.
  class frame_tracker;
    logic [7:0]          ring [DEPTH];
    logic [CW-1:0]       wr_count;
    logic [CW-1:0]       rd_count;
    logic [15:0]         timer;
    logic [15:0]         idle_ticks;
    bit                  ready;
    logic [7:0]          held_len;
    itfr_pkg::result_t   pending_status [$];
    int                  errors;
    int                  checked;

    function new();
      wr_count   = '0;
      rd_count   = '0;
      timer      = '0;
      idle_ticks = itfr_pkg::IDLE_TICKS_RESET;
      ready      = 1'b0;
      held_len   = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function int held_count();
      logic [CW-1:0] n;
      n = wr_count - rd_count;
      return int'(n);
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("MISMATCH at result %0d: %s", checked, msg);
    endtask

    // Advances the predicted state by one item and returns the status it yields.
    function itfr_pkg::result_t next_status(itfr_pkg::item_t it);
      itfr_pkg::result_t r;
      int                n;
      r = '0;
      n = held_count();
      case (it.kind)
        itfr_pkg::KIND_BYTE: begin
          if (ready) begin
            r.byte_dropped = 1'b1;
          end else if ((n % DEPTH) == 0 || timer != 0) begin
            timer = idle_ticks;
            if (n < DEPTH) begin
              ring[wr_count % DEPTH] = it.rx_byte;
              wr_count = wr_count + 1'b1;
            end else begin
              r.byte_dropped = 1'b1;
            end
            held_len = 8'(held_count() % DEPTH);
          end else begin
            r.byte_dropped = 1'b1;
          end
        end
        itfr_pkg::KIND_TICK: begin
          if (timer != 0) timer = timer - 1'b1;
          else if (held_len != 0 && !ready) ready = 1'b1;
        end
        itfr_pkg::KIND_POP: begin
          if (n != 0) begin
            r.pop_data  = ring[rd_count % DEPTH];
            r.pop_valid = 1'b1;
            rd_count = rd_count + 1'b1;
            held_len = 8'(held_count() % DEPTH);
          end
        end
        default: ready = 1'b0;
      endcase
      r.frame_ready  = ready;
      r.frame_length = held_len;
      return r;
    endfunction

    function void take_item(itfr_pkg::item_t it);
      pending_status.push_back(next_status(it));
    endfunction

    task compare_result(input itfr_pkg::result_t got);
      itfr_pkg::result_t want;
      if (pending_status.size() == 0) begin
        report_mismatch("result transfer with no item waiting for it");
        checked++;
        return;
      end
      want = pending_status.pop_front();
      if (got.frame_ready !== want.frame_ready)
        report_mismatch($sformatf("frame_ready %b, expected %b",
                                  got.frame_ready, want.frame_ready));
      if (got.frame_length !== want.frame_length)
        report_mismatch($sformatf("frame_length %0d, expected %0d",
                                  got.frame_length, want.frame_length));
      if (got.pop_data !== want.pop_data)
        report_mismatch($sformatf("pop_data %h, expected %h", got.pop_data, want.pop_data));
      if (got.pop_valid !== want.pop_valid)
        report_mismatch($sformatf("pop_valid %b, expected %b", got.pop_valid, want.pop_valid));
      if (got.byte_dropped !== want.byte_dropped)
        report_mismatch($sformatf("byte_dropped %b, expected %b",
                                  got.byte_dropped, want.byte_dropped));
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        idle_ticks_we;
  logic [15:0] idle_ticks_data;

  itfr_stream_if #(.payload_t(itfr_pkg::item_t))   item_if ();
  itfr_stream_if #(.payload_t(itfr_pkg::result_t)) result_if ();

  idle_timeout_frame_receiver #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .idle_ticks_we   (idle_ticks_we),
    .idle_ticks_data (idle_ticks_data),
    .item            (item_if),
    .result          (result_if)
  );

  frame_tracker sb;

  // Idling switches of the two sides. They are changed only between phases.
  bit tx_idling;
  bit rx_idling;

  always #1 clk = ~clk;

  // Every input of the block is known from time zero.
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    idle_ticks_we   = 1'b0;
    idle_ticks_data = '0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    result_if.ready = 1'b0;
    tx_idling       = 1'b1;
    rx_idling       = 1'b1;
    sb              = new();
  end

  // The receiver stalls in about a quarter of the cycles while its idling is on.
  always @(posedge clk) begin
    if (rst) result_if.ready <= 1'b0;
    else result_if.ready <= !rx_idling || ($urandom_range(99) >= 25);
  end

  // Every result transfer is checked against the oldest prediction. Values read here at the
  // rising edge are the ones from before the edge, the same ones the block acts on.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) sb.compare_result(result_if.payload);
  end

  // A run that hangs, or never delivers a result it owes, ends here.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one item and returns once it has been transferred. Valid is left high, so that the
  // next item can follow back to back; the idle gap, when there is one, lowers it first.
  task automatic send_item(input itfr_pkg::kind_t k, input logic [7:0] b);
    itfr_pkg::item_t it;
    it.kind    = k;
    it.rx_byte = b;
    if (tx_idling && $urandom_range(99) < 25) begin
      item_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    sb.take_item(it);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(itfr_pkg::KIND_TICK, 8'($urandom_range(255)));
  endtask

  // Stops offering items until every result has come back, then lets the block settle.
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The register is only written while the block is idle, so the caller drains first.
  task automatic write_idle_ticks(input logic [15:0] value);
    idle_ticks_data <= value;
    idle_ticks_we   <= 1'b1;
    @(posedge clk);
    idle_ticks_we   <= 1'b0;
    sb.idle_ticks = value;
  endtask

  // One frame as a well-behaved sender and consumer would produce it: bytes with short tick gaps
  // that keep the timer running, enough silence to end the frame, then pops and a release.
  // Some frames end on a byte that comes just after the timer ran out, and some consumers pop
  // only part of the frame, which leaves bytes behind for the next frame to trip over.
  task automatic send_frame(input int nbytes);
    int ticks;
    int gap_max;
    int npop;
    int rel_choice;
    ticks   = int'(sb.idle_ticks);
    gap_max = (ticks > 6) ? 5 : ticks - 1;
    for (int i = 0; i < nbytes; i++) begin
      send_item(itfr_pkg::KIND_BYTE, 8'($urandom_range(255)));
      if (gap_max > 0 && $urandom_range(3) == 0) send_ticks($urandom_range(gap_max));
    end
    // With a long setting the silence that ends a frame is out of reach; such frames stay open.
    if (ticks <= 64) begin
      if ($urandom_range(7) == 0) begin
        send_ticks(ticks);
        send_item(itfr_pkg::KIND_BYTE, 8'($urandom_range(255)));
        send_ticks(1);
      end else begin
        send_ticks(ticks + 1);
      end
    end
    if ($urandom_range(4) == 0) npop = $urandom_range(sb.held_count());
    else npop = sb.held_count() + $urandom_range(1);
    rel_choice = $urandom_range(99);
    if (rel_choice < 15) send_item(itfr_pkg::KIND_RELEASE, 8'($urandom_range(255)));
    repeat (npop) send_item(itfr_pkg::KIND_POP, 8'($urandom_range(255)));
    if (rel_choice >= 30) send_item(itfr_pkg::KIND_RELEASE, 8'($urandom_range(255)));
  endtask

  // Random kinds and bytes with no structure at all.
  task automatic send_noise(input int count);
    repeat (count) send_item(itfr_pkg::kind_t'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = sb.checked + sb.pending();
    while (sb.checked + sb.pending() - start < quota) begin
      if ($urandom_range(99) < 75) begin
        // Now and then a frame near the store depth, which may fill the store and overflow it.
        if ($urandom_range(29) == 0) send_frame($urandom_range(DEPTH - 16, DEPTH + 14));
        else send_frame($urandom_range(1, 12));
      end else begin
        send_noise($urandom_range(1, 8));
      end
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  // Settings of the random phases: a short setting that also carries the overflow frame, the
  // largest setting, a zero setting, the shortest legal one, then two picked at random.
  logic [15:0] phase_ticks [6];

  initial begin
    phase_ticks[0] = 16'd2;
    phase_ticks[1] = 16'hFFFF;
    phase_ticks[2] = 16'd0;
    phase_ticks[3] = 16'd1;
    phase_ticks[4] = 16'($urandom_range(3, 40));
    phase_ticks[5] = 16'($urandom_range(4, 12));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting. A pop and a release find nothing to act on, two bytes
    // at the value extremes open a frame, the timer runs down exactly, and the late byte that
    // follows is refused. The next tick marks the frame, a byte while it is marked is refused,
    // the consumer pops past the end of the data, and a tick on an empty store marks nothing.
    send_item(itfr_pkg::KIND_POP, 8'h00);
    send_item(itfr_pkg::KIND_RELEASE, 8'hFF);
    send_item(itfr_pkg::KIND_BYTE, 8'h00);
    send_item(itfr_pkg::KIND_BYTE, 8'hFF);
    send_ticks(itfr_pkg::IDLE_TICKS_RESET);
    send_item(itfr_pkg::KIND_BYTE, 8'h5A);
    send_item(itfr_pkg::KIND_TICK, 8'hA5);
    send_item(itfr_pkg::KIND_BYTE, 8'hC3);
    send_item(itfr_pkg::KIND_POP, 8'h3C);
    send_item(itfr_pkg::KIND_POP, 8'hFF);
    send_item(itfr_pkg::KIND_POP, 8'h00);
    send_item(itfr_pkg::KIND_RELEASE, 8'h00);
    send_item(itfr_pkg::KIND_TICK, 8'hFF);

    // A release with bytes still held: the next tick marks the same bytes ready again.
    wait_drained();
    write_idle_ticks(16'd1);
    send_item(itfr_pkg::KIND_BYTE, 8'h81);
    send_ticks(2);
    send_item(itfr_pkg::KIND_RELEASE, 8'h7E);
    send_item(itfr_pkg::KIND_TICK, 8'h00);
    send_item(itfr_pkg::KIND_RELEASE, 8'hFF);
    send_item(itfr_pkg::KIND_POP, 8'h00);
    send_item(itfr_pkg::KIND_TICK, 8'h00);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_idle_ticks(phase_ticks[p]);
      // The phase with the setting of one runs with no idling on either side.
      tx_idling = (p != 3);
      rx_idling = (p != 3);
      if (p == 0) begin
        // Fill the store and push a few more bytes at it, then let everything drain before
        // the random frames begin.
        send_frame(DEPTH + 4);
        wait_drained();
      end
      run_phase(PHASE_ITEMS);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/itfr_pkg.sv
rtl/itfr_stream_if.sv
rtl/idle_timeout_frame_receiver.sv
bench/idle_timeout_frame_receiver_tb.sv
